// File: rtl/core/atl_pkg.sv
// Shared widths, types and the arctangent table for the tilt-angle core.
package atl_pkg;

  localparam int AXIS_W            = 16;
  localparam int TILT_W            = 15;
  localparam int NLANE             = 3;
  localparam int IN_DATA_W         = 48;
  localparam int OUT_DATA_W        = 48;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // squares, sums and the digit-by-digit square root
  localparam int SQ_W   = 31;
  localparam int SUM_W  = 32;
  localparam int ROOT_W = 28;
  localparam int REM_W  = 30;
  localparam int WORK_W = REM_W + 2;

  // CORDIC datapath
  localparam int AXIS_SHIFT  = 12;
  localparam int CV_W        = 32;
  localparam int ACC_W       = 32;
  localparam int ANGLE_SHIFT = 16;
  localparam int ANGLE_HALF  = 32768;
  localparam int ANGLE_LIMIT = 9000;

  // atan(2^-i) in hundredths of a degree, Q16
  localparam logic [ACC_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
    32'd11730358,  32'd5866610,   32'd2933484,  32'd1466764,  32'd733385,
    32'd366693,    32'd183346,    32'd91673,    32'd45837,    32'd22918,
    32'd11459,     32'd5730,      32'd2865,     32'd1432,     32'd716,
    32'd358,       32'd179,       32'd90,       32'd45
  };

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  src;
  } sqrt_t;

  typedef struct packed {
    logic signed [CV_W-1:0]  xv;
    logic signed [CV_W-1:0]  yv;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } side_t;

endpackage

// File: rtl/core/atl_sqrt_cell.sv
// One root bit of the pipelined integer square root.
module atl_sqrt_cell import atl_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  sqrt_t dat_r, dat_nxt;
  logic [WORK_W-1:0] cur;
  logic [WORK_W-1:0] trial;

  always_comb begin
    // bring down the next two radicand bits; zeros follow once src is spent
    cur   = {din.rem, din.src[SUM_W-1 -: 2]};
    trial = {{(WORK_W-ROOT_W-2){1'b0}}, din.root, 2'b01};
    dat_nxt.src = {din.src[SUM_W-3:0], 2'b00};
    if (cur >= trial) begin
      dat_nxt.rem  = REM_W'(cur - trial);
      dat_nxt.root = {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      dat_nxt.rem  = cur[REM_W-1:0];
      dat_nxt.root = {din.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign dout = dat_r;

endmodule

// File: rtl/core/atl_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle step.
module atl_cordic_cell import atl_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  localparam logic signed [ACC_W-1:0] ANG = signed'(ATAN_TAB[STAGE]);

  cordic_t dat_r, dat_nxt;
  logic signed [CV_W-1:0] xv, yv, dx, dy;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    xv  = din.xv;
    yv  = din.yv;
    acc = din.acc;
    // arithmetic shifts round toward minus infinity
    dx  = yv >>> STAGE;
    dy  = xv >>> STAGE;
    if (!yv[CV_W-1]) begin
      dat_nxt.xv  = xv + dx;
      dat_nxt.yv  = yv - dy;
      dat_nxt.acc = acc + ANG;
    end else begin
      dat_nxt.xv  = xv - dx;
      dat_nxt.yv  = yv + dy;
      dat_nxt.acc = acc - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign dout = dat_r;

endmodule

// File: rtl/core/accel_tilt_angles_core.sv
// Top level of the accelerometer tilt-angle core: squares, root and CORDIC cell rows.
//
// Input stream: in_tdata carries one signed sample (x, y, z), taken when in_tvalid
// and in_tready are both high. Output stream: out_tdata carries the three tilt
// angles in hundredths of a degree, out_tuser flags an all-zero sample (angles 0).
// Each sample runs through one square stage, one sum stage, a row of 28 root
// cells (one root bit each) and a row of CORDIC_STAGES rotation cells (24 at
// most), then a magnitude stage and the output register. One request is taken
// every cycle while the receiver keeps up, as every cell of both rows is a
// register that takes a new value each time the pipeline is enabled.
// When out_tready is low, one more result drops into a skid register and then
// the whole pipeline holds; in_tready follows that skid register, so the input
// stalls as soon as the skid register is full and nothing is lost. Reset empties the
// pipeline and both output registers; no clearing pass is needed.
module accel_tilt_angles_core import atl_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // tilt_x[14:0], tilt_y[29:15], tilt_z[44:30], 0
  output logic                  out_tuser   // zero_vector[0]
);

  localparam int NSTG   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int SQ_END = ROOT_W + 1;
  localparam int CD_END = SQ_END + NSTG;
  localparam int DEPTH  = CD_END + 2;
  localparam int RES_W  = NLANE * TILT_W;
  localparam logic [TILT_W-1:0] LIM = TILT_W'(ANGLE_LIMIT);

  function automatic logic [TILT_W-1:0] to_tilt(input logic [ACC_W-1:0] mag,
                                                input logic neg);
    logic [ACC_W-1:0] sum;
    logic [ACC_W-ANGLE_SHIFT-1:0] r;
    logic [TILT_W-1:0] lim;
    sum = mag + ACC_W'(ANGLE_HALF);
    r   = sum[ACC_W-1:ANGLE_SHIFT];
    if (r > (ACC_W-ANGLE_SHIFT)'(ANGLE_LIMIT)) begin
      lim = LIM;
    end else begin
      lim = r[TILT_W-1:0];
    end
    return neg ? TILT_W'(-lim) : lim;
  endfunction

  logic en;
  logic [DEPTH-1:0] vld_r;
  side_t sb_r [DEPTH];
  logic [SQ_W-1:0]  sq_r  [NLANE];
  logic [SUM_W-1:0] sum_r [NLANE];
  logic [ACC_W-1:0] mag_r [NLANE];
  logic             neg_r [NLANE];

  sqrt_t   sqc [NLANE][ROOT_W+1];
  cordic_t cdc [NLANE][NSTG+1];

  side_t in_side;
  logic signed [2*AXIS_W-1:0] prod [NLANE];

  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_dat_r, out_dat_nxt;
  logic                  out_usr_r, out_usr_nxt;
  logic                  skid_vld_r, skid_vld_nxt;
  logic [OUT_DATA_W-1:0] skid_dat_r, skid_dat_nxt;
  logic                  skid_usr_r, skid_usr_nxt;
  logic                  out_take, push;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  assign in_side.x = signed'(in_tdata[AXIS_W-1:0]);
  assign in_side.y = signed'(in_tdata[2*AXIS_W-1:AXIS_W]);
  assign in_side.z = signed'(in_tdata[3*AXIS_W-1:2*AXIS_W]);

  assign prod[0] = in_side.x * in_side.x;
  assign prod[1] = in_side.y * in_side.y;
  assign prod[2] = in_side.z * in_side.z;

  // sample delay line and valid bits beside the cell rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_side;
      for (int k = 1; k < DEPTH; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      for (int l = 0; l < NLANE; l++) begin
        sq_r[l] <= prod[l][SQ_W-1:0];
      end
      // lane 0: y^2+z^2, lane 1: x^2+z^2, lane 2: x^2+y^2
      sum_r[0] <= {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      sum_r[1] <= {1'b0, sq_r[0]} + {1'b0, sq_r[2]};
      sum_r[2] <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    end
  end

  // square-root rows
  for (genvar l = 0; l < NLANE; l++) begin : g_sqrt
    assign sqc[l][0] = '{rem: '0, root: '0, src: sum_r[l]};
    for (genvar j = 0; j < ROOT_W; j++) begin : g_cell
      atl_sqrt_cell u_cell (
        .clk  (clk),
        .en   (en),
        .din  (sqc[l][j]),
        .dout (sqc[l][j+1])
      );
    end
  end

  // CORDIC start vectors
  logic signed [AXIS_W:0] zext;
  logic [AXIS_W:0]        az;

  always_comb begin
    zext = {sb_r[SQ_END].z[AXIS_W-1], sb_r[SQ_END].z};
    az   = zext[AXIS_W] ? unsigned'(-zext) : unsigned'(zext);
    cdc[0][0].xv  = {{(CV_W-ROOT_W){1'b0}}, sqc[0][ROOT_W].root};
    cdc[0][0].yv  = {{(CV_W-AXIS_W-AXIS_SHIFT){sb_r[SQ_END].x[AXIS_W-1]}},
                     sb_r[SQ_END].x, {AXIS_SHIFT{1'b0}}};
    cdc[0][0].acc = '0;
    cdc[1][0].xv  = {{(CV_W-ROOT_W){1'b0}}, sqc[1][ROOT_W].root};
    cdc[1][0].yv  = {{(CV_W-AXIS_W-AXIS_SHIFT){sb_r[SQ_END].y[AXIS_W-1]}},
                     sb_r[SQ_END].y, {AXIS_SHIFT{1'b0}}};
    cdc[1][0].acc = '0;
    cdc[2][0].xv  = {{(CV_W-AXIS_W-1-AXIS_SHIFT){1'b0}}, az, {AXIS_SHIFT{1'b0}}};
    cdc[2][0].yv  = {{(CV_W-ROOT_W){1'b0}}, sqc[2][ROOT_W].root};
    cdc[2][0].acc = '0;
  end

  // CORDIC rows
  for (genvar l = 0; l < NLANE; l++) begin : g_cordic
    for (genvar k = 0; k < NSTG; k++) begin : g_cell
      atl_cordic_cell #(
        .STAGE (k)
      ) u_cell (
        .clk  (clk),
        .en   (en),
        .din  (cdc[l][k]),
        .dout (cdc[l][k+1])
      );
    end
  end

  // sign and magnitude of each angle; the z angle takes the sign of z
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        mag_r[l] <= cdc[l][NSTG].acc[ACC_W-1] ? unsigned'(-cdc[l][NSTG].acc)
                                               : unsigned'(cdc[l][NSTG].acc);
      end
      neg_r[0] <= cdc[0][NSTG].acc[ACC_W-1];
      neg_r[1] <= cdc[1][NSTG].acc[ACC_W-1];
      neg_r[2] <= cdc[2][NSTG].acc[ACC_W-1] ^ sb_r[CD_END].z[AXIS_W-1];
    end
  end

  // rounding, clamping and the special cases
  side_t fin;
  logic zero_all, x_nz, y_nz, z_nz;
  logic [TILT_W-1:0] tx, ty, tz;
  logic [OUT_DATA_W-1:0] res_dat;

  always_comb begin
    fin      = sb_r[DEPTH-1];
    x_nz     = (fin.x != '0);
    y_nz     = (fin.y != '0);
    z_nz     = (fin.z != '0);
    zero_all = !x_nz && !y_nz && !z_nz;
    if (zero_all) begin
      tx = '0;
      ty = '0;
      tz = '0;
    end else begin
      if (!y_nz && !z_nz) begin
        tx = fin.x[AXIS_W-1] ? TILT_W'(-LIM) : LIM;
      end else begin
        tx = to_tilt(mag_r[0], neg_r[0]);
      end
      if (!x_nz && !z_nz) begin
        ty = fin.y[AXIS_W-1] ? TILT_W'(-LIM) : LIM;
      end else begin
        ty = to_tilt(mag_r[1], neg_r[1]);
      end
      if (!z_nz) begin
        tz = LIM;
      end else begin
        tz = to_tilt(mag_r[2], neg_r[2]);
      end
    end
    res_dat = {{(OUT_DATA_W-RES_W){1'b0}}, tz, ty, tx};
  end

  // output register with skid
  always_comb begin
    out_take     = out_vld_r && out_tready;
    push         = en && vld_r[DEPTH-1];
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    out_usr_nxt  = out_usr_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    skid_usr_nxt = skid_usr_r;
    if (out_take) begin
      out_vld_nxt = 1'b0;
    end
    if (skid_vld_r && out_take) begin
      out_vld_nxt  = 1'b1;
      out_dat_nxt  = skid_dat_r;
      out_usr_nxt  = skid_usr_r;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      if (!out_vld_r || out_take) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = res_dat;
        out_usr_nxt = zero_all;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_dat_nxt = res_dat;
        skid_usr_nxt = zero_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    out_usr_r  <= out_usr_nxt;
    skid_dat_r <= skid_dat_nxt;
    skid_usr_r <= skid_usr_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_usr_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && en && vld_r[DEPTH-1]) |=> skid_vld_r)
    else $error("result leaving the pipeline under stall did not reach the skid");

  a_zero_vector_angles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_usr_r) |-> (out_dat_r == '0))
    else $error("all-zero sample gave nonzero angles");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |->
      ($signed(out_dat_r[TILT_W-1:0]) <= $signed(LIM)) &&
      ($signed(out_dat_r[TILT_W-1:0]) >= -$signed(LIM)) &&
      ($signed(out_dat_r[2*TILT_W-1:TILT_W]) <= $signed(LIM)) &&
      ($signed(out_dat_r[2*TILT_W-1:TILT_W]) >= -$signed(LIM)) &&
      ($signed(out_dat_r[RES_W-1:2*TILT_W]) <= $signed(LIM)) &&
      ($signed(out_dat_r[RES_W-1:2*TILT_W]) >= -$signed(LIM)))
    else $error("tilt angle outside the clamp range");
`endif

endmodule

// File: verif/tilt_check_pkg.sv
// Scoreboard for the tilt-angle core: fixed-point angle predictor and result checker.
package tilt_check_pkg;
  import atl_pkg::*;

  class tilt_scoreboard;
    typedef struct {
      logic signed [TILT_W-1:0] tx;
      logic signed [TILT_W-1:0] ty;
      logic signed [TILT_W-1:0] tz;
      logic                     zero;
    } angles_t;

    // atan(2^-k) in centidegrees scaled by 2^16
    localparam longint ARCTAN_Q16 [24] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45
    };
    localparam longint RIGHT_ANGLE = 9000;

    angles_t pending_q[$];
    int      n_err;
    int      n_req;
    int      n_res;
    int      n_zero;
    int      n_edge;

    function void report_mismatch(string msg);
      n_err++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // floor(2^12 * sqrt(a^2 + b^2))
    function longint radius_q12(longint a, longint b);
      longint unsigned s;
      s = longint'(a * a + b * b);
      return longint'(root_floor(s << 24));
    endfunction

    // vectoring rotations; the accumulated angle of (xv, yv), xv >= 0
    function longint vector_angle(longint xv, longint yv);
      longint acc;
      longint dx;
      longint dy;
      int     n;
      acc = 0;
      n = (CORDIC_STAGES_DEF > 24) ? 24 : CORDIC_STAGES_DEF;
      for (int k = 0; k < n; k++) begin
        dx = yv >>> k;
        dy = xv >>> k;
        if (yv >= 0) begin
          xv = xv + dx;
          yv = yv - dy;
          acc = acc + ARCTAN_Q16[k];
        end else begin
          xv = xv - dx;
          yv = yv + dy;
          acc = acc - ARCTAN_Q16[k];
        end
      end
      return acc;
    endfunction

    function longint round_centideg(longint acc);
      longint r;
      if (acc >= 0) r = (acc + 32768) >>> 16;
      else          r = -((-acc + 32768) >>> 16);
      if (r > RIGHT_ANGLE)  r = RIGHT_ANGLE;
      if (r < -RIGHT_ANGLE) r = -RIGHT_ANGLE;
      return r;
    endfunction

    // atan(num / sqrt(a^2 + b^2))
    function longint side_angle(longint num, longint a, longint b);
      if (a == 0 && b == 0) begin
        n_edge++;
        if (num > 0) return RIGHT_ANGLE;
        if (num < 0) return -RIGHT_ANGLE;
        return 0;
      end
      return round_centideg(vector_angle(radius_q12(a, b), num * 4096));
    endfunction

    function void note_request(logic signed [AXIS_W-1:0] ax, logic signed [AXIS_W-1:0] ay,
                               logic signed [AXIS_W-1:0] az);
      angles_t e;
      longint  x;
      longint  y;
      longint  z;
      longint  tz;
      x = ax;
      y = ay;
      z = az;
      n_req++;
      e.tx = '0;
      e.ty = '0;
      e.tz = '0;
      e.zero = 1'b0;
      if (x == 0 && y == 0 && z == 0) begin
        e.zero = 1'b1;
        n_zero++;
      end else begin
        e.tx = TILT_W'(side_angle(x, y, z));
        e.ty = TILT_W'(side_angle(y, x, z));
        if (z == 0) begin
          tz = RIGHT_ANGLE;
        end else begin
          tz = round_centideg(vector_angle(((z < 0) ? -z : z) * 4096, radius_q12(x, y)));
          if (z < 0) tz = -tz;
        end
        e.tz = TILT_W'(tz);
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic zero_flag);
      angles_t                  e;
      logic signed [TILT_W-1:0] gx;
      logic signed [TILT_W-1:0] gy;
      logic signed [TILT_W-1:0] gz;
      n_res++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding", n_res));
        return;
      end
      e = pending_q.pop_front();
      gx = d[TILT_W-1:0];
      gy = d[2*TILT_W-1:TILT_W];
      gz = d[3*TILT_W-1:2*TILT_W];
      if (gx !== e.tx)
        report_mismatch($sformatf("result %0d tilt_x got %0d want %0d", n_res, gx, e.tx));
      if (gy !== e.ty)
        report_mismatch($sformatf("result %0d tilt_y got %0d want %0d", n_res, gy, e.ty));
      if (gz !== e.tz)
        report_mismatch($sformatf("result %0d tilt_z got %0d want %0d", n_res, gz, e.tz));
      if (zero_flag !== e.zero)
        report_mismatch($sformatf("result %0d zero_vector got %b want %b",
                                  n_res, zero_flag, e.zero));
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass
endpackage

// File: verif/tb_top.sv
// Top-level testbench for the tilt-angle core: stream drivers, monitors and run control.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atl_pkg::*;
  import tilt_check_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  tilt_scoreboard sb = new();

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_cycles = 0;

  accel_tilt_angles_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken, or later after a random gap
  task automatic send_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                             logic signed [AXIS_W-1:0] z);
    in_tdata = {z, y, x};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_random();
    logic signed [AXIS_W-1:0] v [3];
    int                       kind;
    int                       k;
    kind = $urandom_range(0, 9);
    k = $urandom_range(0, 2);
    for (int a = 0; a < 3; a++) begin
      case (kind)
        5, 6: begin
          v[a] = AXIS_W'(int'($urandom_range(0, 128)) - 64);
        end
        7: begin
          v[a] = (a == k) ? '0 : AXIS_W'($urandom);
        end
        8: begin
          v[a] = (a == k) ? AXIS_W'($urandom) : '0;
        end
        9: begin
          case ($urandom_range(0, 5))
            0: v[a] = 16'sh8000;
            1: v[a] = 16'sh8001;
            2: v[a] = -16'sd1;
            3: v[a] = 16'sd0;
            4: v[a] = 16'sd1;
            default: v[a] = 16'sh7fff;
          endcase
        end
        default: begin
          v[a] = AXIS_W'($urandom);
        end
      endcase
    end
    send_sample(v[0], v[1], v[2]);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // all-zero sample, zero denominators, z on the axis, sign of z, extremes
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd0, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd100, -16'sd200, 16'sd0);
    send_sample(16'sd300, 16'sd400, -16'sd500);
    send_sample(-16'sd300, -16'sd400, 16'sd500);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sh7fff, 16'sd1, 16'sd1);
    send_sample(16'sd1, 16'sd1, 16'sh8000);
    send_sample(16'sd0, 16'sd16384, -16'sd16384);

    repeat (600) send_random();

    // long receiver hold while requests keep coming: pipeline fills, input stalls
    tx_gaps_on = 1'b0;
    hold_cycles = 300;
    hold_req = 1'b1;
    repeat (150) send_random();
    in_tvalid = 1'b0;
    tx_gaps_on = 1'b1;
    // sender pause until the pipeline has drained
    while (sb.outstanding() != 0) @(negedge clk);

    repeat (700) send_random();

    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (276) send_random();
    in_tvalid = 1'b0;

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (CORDIC_STAGES_DEF + 40) @(negedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.outstanding()));

    $display("Ran %0d samples (%0d all-zero, %0d with a zero denominator), %0d results checked",
             sb.n_req, sb.n_zero, sb.n_edge, sb.n_res);
    $display("Traffic had random gaps, a %0d-cycle output hold and a full drain; %0d mismatches",
             hold_cycles, sb.n_err);
    if (sb.n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
